>>> hw/rtl/lcab_pkg.sv
// Shared types, opcodes and the microprogram for the binary-lifting LCA engine.
// No dependencies; imported by lcab_seq, lcab_dp and lca_binary_lifting.
`timescale 1ns / 1ps
`default_nettype none

package lcab_pkg;

    localparam int NODE_W  = 10;   // width of a node id on the ports
    localparam int DEPTH_W = 10;   // depth of any loadable node fits here
    localparam int PC_W    = 4;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } req_t;

    typedef struct packed {
        logic [NODE_W-1:0] ancestor;
        logic              status;
    } rsp_t;

    // datapath operations
    typedef logic [3:0] op_t;
    localparam op_t OP_NOP   = 4'd0;
    localparam op_t OP_CLR   = 4'd1;
    localparam op_t OP_LOAD  = 4'd2;
    localparam op_t OP_ACHK  = 4'd3;
    localparam op_t OP_FILL  = 4'd4;
    localparam op_t OP_QCHK  = 4'd5;
    localparam op_t OP_LIFT  = 4'd6;
    localparam op_t OP_QEQ   = 4'd7;
    localparam op_t OP_MEET  = 4'd8;
    localparam op_t OP_QLAST = 4'd9;
    localparam op_t OP_EMIT  = 4'd10;

    // hold conditions: the step repeats while the condition is unmet
    typedef logic [2:0] wait_t;
    localparam wait_t W_NONE = 3'd0;
    localparam wait_t W_IN   = 3'd1;
    localparam wait_t W_OUT  = 3'd2;
    localparam wait_t W_NZ   = 3'd3;
    localparam wait_t W_FILL = 3'd4;
    localparam wait_t W_CLR  = 3'd5;

    // jump conditions, checked once the step no longer holds
    typedef logic [2:0] jump_t;
    localparam jump_t J_NONE   = 3'd0;
    localparam jump_t J_ALWAYS = 3'd1;
    localparam jump_t J_QUERY  = 3'd2;
    localparam jump_t J_ERR    = 3'd3;
    localparam jump_t J_SAME   = 3'd4;

    typedef logic [PC_W-1:0] pc_t;
    localparam pc_t PC_CLR   = 4'd0;
    localparam pc_t PC_IDLE  = 4'd1;
    localparam pc_t PC_ACHK  = 4'd2;
    localparam pc_t PC_FILL  = 4'd3;
    localparam pc_t PC_QCHK  = 4'd4;
    localparam pc_t PC_LIFT  = 4'd5;
    localparam pc_t PC_QEQ   = 4'd6;
    localparam pc_t PC_MEET  = 4'd7;
    localparam pc_t PC_QLAST = 4'd8;
    localparam pc_t PC_EMIT  = 4'd9;

    typedef struct packed {
        op_t   op;
        wait_t wt;
        jump_t jmp;
        pc_t   tgt;
    } uword_t;

    // sequencer -> datapath
    typedef struct packed {
        op_t  op;
        logic step_en;   // low while an IDLE/EMIT step waits on a handshake
    } ctrl_t;

    // datapath -> sequencer
    typedef struct packed {
        logic query;
        logic err;
        logic same;
        logic lev_zero;
        logic fill_last;
        logic clr_last;
    } stat_t;

    function automatic uword_t ucode(input pc_t pc);
        uword_t w;
        case (pc)
            PC_CLR:   w = '{op: OP_CLR,   wt: W_CLR,  jmp: J_NONE,   tgt: PC_IDLE};
            PC_IDLE:  w = '{op: OP_LOAD,  wt: W_IN,   jmp: J_QUERY,  tgt: PC_QCHK};
            PC_ACHK:  w = '{op: OP_ACHK,  wt: W_NONE, jmp: J_ERR,    tgt: PC_EMIT};
            PC_FILL:  w = '{op: OP_FILL,  wt: W_FILL, jmp: J_ALWAYS, tgt: PC_EMIT};
            PC_QCHK:  w = '{op: OP_QCHK,  wt: W_NONE, jmp: J_ERR,    tgt: PC_EMIT};
            PC_LIFT:  w = '{op: OP_LIFT,  wt: W_NZ,   jmp: J_NONE,   tgt: PC_QEQ};
            PC_QEQ:   w = '{op: OP_QEQ,   wt: W_NONE, jmp: J_SAME,   tgt: PC_EMIT};
            PC_MEET:  w = '{op: OP_MEET,  wt: W_NZ,   jmp: J_NONE,   tgt: PC_QLAST};
            PC_QLAST: w = '{op: OP_QLAST, wt: W_NONE, jmp: J_NONE,   tgt: PC_EMIT};
            PC_EMIT:  w = '{op: OP_EMIT,  wt: W_OUT,  jmp: J_ALWAYS, tgt: PC_IDLE};
            default:  w = '{op: OP_NOP,   wt: W_NONE, jmp: J_ALWAYS, tgt: PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lcab_seq.sv
// Microcode sequencer: program counter, control ROM lookup, hold and jump logic.
// Depends on lcab_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lcab_seq (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_ready,
    input  wire logic            out_free,
    input  wire lcab_pkg::stat_t stat,
    output lcab_pkg::ctrl_t      ctrl
);
    import lcab_pkg::*;

    pc_t    pc_reg;
    pc_t    pc_next;
    uword_t uw;
    logic   hold;
    logic   jump;

    always_comb
    begin
        uw = ucode(pc_reg);

        case (uw.wt)
            W_NONE:  hold = 1'b0;
            W_IN:    hold = !req_valid;
            W_OUT:   hold = !out_free;
            W_NZ:    hold = !stat.lev_zero;
            W_FILL:  hold = !stat.fill_last;
            W_CLR:   hold = !stat.clr_last;
            default: hold = 1'b0;
        endcase

        case (uw.jmp)
            J_NONE:   jump = 1'b0;
            J_ALWAYS: jump = 1'b1;
            J_QUERY:  jump = stat.query;
            J_ERR:    jump = stat.err;
            J_SAME:   jump = stat.same;
            default:  jump = 1'b0;
        endcase

        if (hold)
        begin
            pc_next = pc_reg;
        end
        else if (jump)
        begin
            pc_next = uw.tgt;
        end
        else
        begin
            pc_next = pc_reg + pc_t'(1);
        end

        req_ready    = (uw.wt == W_IN);
        ctrl.op      = uw.op;
        // loops run their op every pass; handshake waits do not
        ctrl.step_en = !(hold && (uw.wt == W_IN || uw.wt == W_OUT));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_CLR;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    // program counter stays inside the microprogram
    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg <= PC_EMIT)
        else $error("sequencer left the microprogram");

endmodule

`default_nettype wire

>>> hw/rtl/lcab_dp.sv
// Datapath: working registers, ancestor/depth/loaded-flag memories and step ops.
// Depends on lcab_pkg; driven by lcab_seq control words.
`timescale 1ns / 1ps
`default_nettype none

module lcab_dp #(
    parameter int NODES  = 1024,
    parameter int LEVELS = 10
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire lcab_pkg::ctrl_t ctrl,
    input  wire lcab_pkg::req_t  req,
    output lcab_pkg::stat_t      stat,
    output lcab_pkg::rsp_t       res
);
    import lcab_pkg::*;

    // node ids are NODE_W bits wide, so at most 2^NODE_W table rows are reachable
    localparam int SLOTS   = (NODES < (1 << NODE_W)) ? NODES : (1 << NODE_W);
    localparam int ADDR_W  = $clog2(SLOTS);
    localparam int LEV_W   = $clog2(LEVELS);
    localparam int ANC_D   = SLOTS * (1 << LEV_W);
    localparam int ANC_AW  = ADDR_W + LEV_W;

    logic [NODE_W-1:0]  u_reg, u_next;
    logic [NODE_W-1:0]  v_reg, v_next;
    logic [NODE_W-1:0]  a_reg, a_next;
    logic [LEV_W-1:0]   lev_reg, lev_next;
    logic [DEPTH_W-1:0] diff_reg, diff_next;
    logic [NODE_W-1:0]  res_reg, res_next;
    logic               st_reg, st_next;
    logic [ADDR_W-1:0]  clr_reg, clr_next;

    // memories; read ports follow the next-state addresses so that the
    // registered read data always belongs to the current u/v/lev
    logic [NODE_W-1:0]  anc_mem [ANC_D];
    logic [DEPTH_W-1:0] dep_mem [SLOTS];
    logic               flag_mem [SLOTS];

    logic [NODE_W-1:0]  ru_rd, rv_rd;
    logic [DEPTH_W-1:0] du_rd, dv_rd;
    logic               fu_rd, fv_rd;

    logic               anc_we;
    logic [ANC_AW-1:0]  anc_waddr;
    logic [NODE_W-1:0]  anc_wdata;
    logic               dep_we;
    logic [DEPTH_W-1:0] dep_wdata;
    logic               flag_we;
    logic [ADDR_W-1:0]  flag_waddr;
    logic               flag_wdata;

    logic [NODE_W-1:0]  ru, rv;
    logic               err_add, err_qry;
    logic [31:0]        pow;
    logic               take;

    function automatic logic node_ok(input logic [NODE_W-1:0] n);
        return (n != '0) && (32'(n) < NODES);
    endfunction

    always_comb
    begin
        // row 0 stands for "none" and reads as zero
        ru = (u_reg == '0) ? '0 : ru_rd;
        rv = (v_reg == '0) ? '0 : rv_rd;

        err_add = !node_ok(u_reg) || fu_rd ||
                  ((v_reg != '0) && (!node_ok(v_reg) || !fv_rd));
        err_qry = !node_ok(u_reg) || !node_ok(v_reg) || !fu_rd || !fv_rd;

        pow  = 32'd1 << lev_reg;
        take = (32'(diff_reg) >= pow);

        u_next     = u_reg;
        v_next     = v_reg;
        a_next     = a_reg;
        lev_next   = lev_reg;
        diff_next  = diff_reg;
        res_next   = res_reg;
        st_next    = st_reg;
        clr_next   = clr_reg;
        anc_we     = 1'b0;
        anc_waddr  = {ADDR_W'(a_reg), lev_reg + LEV_W'(1)};
        anc_wdata  = ru;
        dep_we     = 1'b0;
        dep_wdata  = (v_reg == '0) ? '0 : DEPTH_W'(dv_rd + DEPTH_W'(1));
        flag_we    = 1'b0;
        flag_waddr = ADDR_W'(a_reg);
        flag_wdata = 1'b1;

        case (ctrl.op)
            OP_CLR:
            begin
                flag_we    = 1'b1;
                flag_waddr = clr_reg;
                flag_wdata = 1'b0;
                clr_next   = clr_reg + ADDR_W'(1);
            end
            OP_LOAD:
            begin
                if (ctrl.step_en)
                begin
                    u_next = req.node_a;
                    v_next = req.node_b;
                    a_next = req.node_a;
                end
            end
            OP_ACHK:
            begin
                res_next = '0;
                st_next  = err_add;
                if (!err_add)
                begin
                    anc_we    = 1'b1;
                    anc_waddr = {ADDR_W'(u_reg), LEV_W'(0)};
                    anc_wdata = v_reg;
                    dep_we    = 1'b1;
                    flag_we   = 1'b1;
                    flag_waddr = ADDR_W'(u_reg);
                    u_next    = v_reg;        // walk pointer starts at the parent
                    lev_next  = '0;
                end
            end
            OP_FILL:
            begin
                // level k+1 of the new node = level k of its level-k ancestor
                anc_we   = 1'b1;
                u_next   = ru;
                lev_next = lev_reg + LEV_W'(1);
            end
            OP_QCHK:
            begin
                res_next = '0;
                st_next  = err_qry;
                lev_next = LEV_W'(LEVELS - 1);
                if (du_rd < dv_rd)
                begin
                    u_next    = v_reg;
                    v_next    = u_reg;
                    diff_next = dv_rd - du_rd;
                end
                else
                begin
                    diff_next = du_rd - dv_rd;
                end
            end
            OP_LIFT:
            begin
                if (take)
                begin
                    u_next    = ru;
                    diff_next = diff_reg - DEPTH_W'(pow);
                end
                lev_next = (lev_reg == '0) ? LEV_W'(LEVELS - 1) : lev_reg - LEV_W'(1);
            end
            OP_QEQ:
            begin
                res_next = u_reg;
                st_next  = 1'b0;
            end
            OP_MEET:
            begin
                if ((ru != '0) && (ru != rv))
                begin
                    u_next = ru;
                    v_next = rv;
                end
                lev_next = (lev_reg == '0) ? '0 : lev_reg - LEV_W'(1);
            end
            OP_QLAST:
            begin
                res_next = ru;
                st_next  = 1'b0;
            end
            default:
            begin
            end
        endcase

        stat.query     = (req.cmd == CMD_QUERY);
        stat.err       = (ctrl.op == OP_QCHK) ? err_qry : err_add;
        stat.same      = (u_reg == v_reg);
        stat.lev_zero  = (lev_reg == '0);
        stat.fill_last = (lev_reg == LEV_W'(LEVELS - 2));
        stat.clr_last  = (clr_reg == ADDR_W'(SLOTS - 1));

        res.ancestor = res_reg;
        res.status   = st_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else
        begin
            clr_reg <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg    <= u_next;
        v_reg    <= v_next;
        a_reg    <= a_next;
        lev_reg  <= lev_next;
        diff_reg <= diff_next;
        res_reg  <= res_next;
        st_reg   <= st_next;
    end

    always_ff @(posedge clk)
    begin
        if (anc_we)
        begin
            anc_mem[anc_waddr] <= anc_wdata;
        end
        ru_rd <= anc_mem[{ADDR_W'(u_next), lev_next}];
        rv_rd <= anc_mem[{ADDR_W'(v_next), lev_next}];
    end

    always_ff @(posedge clk)
    begin
        if (dep_we)
        begin
            dep_mem[ADDR_W'(a_reg)] <= dep_wdata;
        end
        du_rd <= dep_mem[ADDR_W'(u_next)];
        dv_rd <= dep_mem[ADDR_W'(v_next)];
    end

    always_ff @(posedge clk)
    begin
        if (flag_we)
        begin
            flag_mem[flag_waddr] <= flag_wdata;
        end
        fu_rd <= flag_mem[ADDR_W'(u_next)];
        fv_rd <= flag_mem[ADDR_W'(v_next)];
    end

    // after the check the deeper node sits in u (read-ahead depth must agree)
    a_swap_order: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == OP_QCHK && !err_qry) |=> (du_rd >= dv_rd))
        else $error("query operands not ordered by depth");

    // lifting only ever shrinks the depth gap
    a_lift_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == OP_LIFT) |=> (diff_reg <= $past(diff_reg)))
        else $error("depth gap grew while lifting");

endmodule

`default_nettype wire

>>> hw/rtl/lca_binary_lifting.sv
// Top level of the binary-lifting lowest-common-ancestor engine.
// Depends on lcab_pkg, lcab_seq (microcode sequencer) and lcab_dp (datapath).
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                       Payload (lcab_pkg)   Role
// req       req_valid, req_ready, req     req_t {cmd, a, b}    add node / LCA query
// rsp       rsp_valid, rsp_ready, rsp     rsp_t {anc, status}  one per request
//
// Steps (accept to accept, with rsp taken promptly):
//   add   : one ancestor level is written per cycle.
//   query : one table read per level in the lift
//           pass and again in the meet pass (skips the meet if already equal).
//   error : the check step goes straight to the emit step.
// Reset: after rst_n rises the loaded-flag memory is swept, one entry per cycle,
//   with req_ready low.
// Stalls: rsp sits in its own register; a new transaction is taken while it
//   waits, and only the emit step holds if the previous response is still there.

module lca_binary_lifting #(
    parameter int NODES  = 1024,
    parameter int LEVELS = 10
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire lcab_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output lcab_pkg::rsp_t      rsp
);
    import lcab_pkg::*;

    ctrl_t ctrl;
    stat_t stat;
    rsp_t  res;

    logic  rsp_valid_reg, rsp_valid_next;
    rsp_t  rsp_reg;
    logic  out_free;
    logic  emit_ld;

    // the output slot is free when empty or being drained this cycle
    assign out_free = !rsp_valid_reg || rsp_ready;
    assign emit_ld  = (ctrl.op == OP_EMIT) && ctrl.step_en;

    lcab_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .out_free  (out_free),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    lcab_dp #(
        .NODES  (NODES),
        .LEVELS (LEVELS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .req   (req),
        .stat  (stat),
        .res   (res)
    );

    always_comb
    begin
        if (emit_ld)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_ld)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // a pending response is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit_ld |-> (!rsp_valid_reg || rsp_ready))
        else $error("response register overwritten while pending");

endmodule

`default_nettype wire

>>> bench/lcab_answer_check.sv
// Watches both channels of lca_binary_lifting, predicts every response and compares it.
// Depends on lcab_pkg for the payload types and command codes.
`timescale 1ns / 1ps

module lcab_answer_check (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic             req_ready,
    input  lcab_pkg::req_t   req,
    input  logic             rsp_valid,
    input  logic             rsp_ready,
    input  lcab_pkg::rsp_t   rsp,
    output int               mismatches,
    output int               waiting
);
    import lcab_pkg::*;

    localparam int NODE_CNT    = 1024;
    localparam int LIFT_LEVELS = 10;

    typedef logic [NODE_W-1:0] node_t;

    node_t       lift_tbl [NODE_CNT][LIFT_LEVELS];
    int unsigned depth_of [NODE_CNT];
    bit          present  [NODE_CNT];

    rsp_t answers_due[$];
    req_t asked_log[$];

    initial mismatches = 0;
    initial waiting    = 0;

    function automatic node_t jump(input node_t n, input int k);
        if (n == '0 || k >= LIFT_LEVELS)
            return '0;
        return lift_tbl[n][k];
    endfunction

    function automatic node_t common_ancestor(input node_t a, input node_t b);
        node_t u, v, t, au, av;
        int    e;
        u = a;
        v = b;
        if (depth_of[u] < depth_of[v])
        begin
            t = u;
            u = v;
            v = t;
        end
        // raise the deeper node to the depth of the other
        for (e = LIFT_LEVELS - 1; e >= 0; e--)
            if (depth_of[u] >= depth_of[v] + (32'd1 << e))
                u = jump(u, e);
        if (u == v)
            return u;
        // climb together while the ancestors still differ
        for (e = LIFT_LEVELS - 1; e >= 0; e--)
        begin
            au = jump(u, e);
            av = jump(v, e);
            if (au != '0 && au != av)
            begin
                u = au;
                v = av;
            end
        end
        return jump(u, 0);
    endfunction

    // updates the tree for an add and returns the response for any request
    function automatic rsp_t apply_request(input req_t r);
        rsp_t  x;
        node_t a, b;
        int    k;
        x = '0;
        a = r.node_a;
        b = r.node_b;
        if (r.cmd == CMD_ADD)
        begin
            if (a == '0 || present[a])
                x.status = 1'b1;
            else if (b != '0 && !present[b])
                x.status = 1'b1;
            else
            begin
                lift_tbl[a][0] = b;
                depth_of[a]    = (b == '0) ? 0 : depth_of[b] + 1;
                for (k = 1; k < LIFT_LEVELS; k++)
                    lift_tbl[a][k] = jump(lift_tbl[a][k-1], k - 1);
                present[a] = 1'b1;
            end
        end
        else if (a == '0 || b == '0 || !present[a] || !present[b])
            x.status = 1'b1;
        else
            x.ancestor = common_ancestor(a, b);
        return x;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        req_t asked;
        if (!rst_n)
        begin
            foreach (present[i])
                present[i] = 1'b0;
            answers_due.delete();
            asked_log.delete();
            waiting = 0;
        end
        else
        begin
            // retire first: a response can never belong to a request taken on the same edge
            if (rsp_valid && rsp_ready)
            begin
                if (answers_due.size() == 0)
                    report_mismatch($sformatf("response with none outstanding: anc %0d st %0d",
                                              rsp.ancestor, rsp.status));
                else
                begin
                    want  = answers_due.pop_front();
                    asked = asked_log.pop_front();
                    if (rsp.ancestor !== want.ancestor)
                        report_mismatch($sformatf("cmd %0d a %0d b %0d: ancestor %0d, want %0d",
                                                  asked.cmd, asked.node_a, asked.node_b,
                                                  rsp.ancestor, want.ancestor));
                    if (rsp.status !== want.status)
                        report_mismatch($sformatf("cmd %0d a %0d b %0d: status %0d, want %0d",
                                                  asked.cmd, asked.node_a, asked.node_b,
                                                  rsp.status, want.status));
                end
            end
            if (req_valid && req_ready)
            begin
                answers_due.push_back(apply_request(req));
                asked_log.push_back(req);
            end
            waiting = answers_due.size();
        end
    end

endmodule

>>> bench/lca_binary_lifting_tb.sv
// Top of the lca_binary_lifting bench: clock, reset, request stimulus and response stalls.
// Depends on lcab_pkg, the RTL under hw/rtl and bench/lcab_answer_check.sv.
`timescale 1ns / 1ps

module lca_binary_lifting_tb;
    import lcab_pkg::*;

    // Sizing. A query is the slowest transaction; the directed and RANDOM_ITEMS random
    // transactions, with sender gaps, receiver stalls and the flag sweep after reset,
    // fit well inside the limit, which is several times the expected run.
    localparam int RANDOM_ITEMS = 525;
    localparam int DRAIN_CYCLES = 40;        // covers the longest query latency
    localparam int CYCLE_LIMIT  = 200_000;
    localparam int MAX_ID       = 1023;      // highest node id on the ports

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    int mismatches;
    int waiting;
    int cycle_cnt = 0;

    // Stimulus-side view of the tree: which ids are loaded, so that most transactions
    // are well formed. The checker keeps its own full model.
    bit loaded [MAX_ID+1];
    int loaded_ids[$];
    int tip = 0;            // bottom of the long chain that grows through the run

    // Receiver stall pattern: an 8-bit mask, walked one bit per cycle and swapped for a new
    // one whenever pat_age runs out. A quarter of the masks are all ones (no stalls at all).
    logic [7:0] stall_pat = 8'hFF;
    logic [5:0] pat_age   = '0;

    always #6 clk = ~clk;

    lca_binary_lifting u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    lcab_answer_check u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .mismatches (mismatches),
        .waiting    (waiting)
    );

    // Hard stop if the block hangs or loses a response.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            stall_pat <= 8'hFF;
            pat_age   <= '0;
        end
        else
        begin
            if (pat_age == 6'd39)
            begin
                pat_age   <= '0;
                // never all zeros: bit 0 is always set, so no stall lasts a whole pass of the mask
                stall_pat <= ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
            end
            else
                pat_age <= pat_age + 6'd1;
            rsp_ready <= stall_pat[pat_age[2:0]];
        end
    end

    function automatic int pick_loaded();
        return loaded_ids[$urandom_range(0, loaded_ids.size() - 1)];
    endfunction

    // an id that is not loaded yet (the tree never gets near full)
    function automatic int pick_fresh();
        int n;
        n = $urandom_range(1, MAX_ID);
        while (loaded[n])
            n = $urandom_range(1, MAX_ID);
        return n;
    endfunction

    // Present one transaction and hold it until the block takes it. Valid is left high
    // on return so back-to-back transactions follow without a gap.
    task automatic send(input logic cmd, input int a, input int b);
        req_t item;
        item.cmd    = cmd;
        item.node_a = a[NODE_W-1:0];
        item.node_b = b[NODE_W-1:0];
        // a well-formed add grows the tree; extending the chain bottom moves the tip down
        if (cmd == CMD_ADD && a != 0 && !loaded[a] && (b == 0 || loaded[b]))
        begin
            loaded[a] = 1'b1;
            loaded_ids.push_back(a);
            if (b == tip)
                tip = a;
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    // sender idle gap; a zero gap keeps valid asserted
    task automatic pause(input int cycles);
        if (cycles > 0)
        begin
            req_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    initial
    begin
        int rand_cnt;
        int burst;
        int roll;
        int fresh;
        int par;
        int qa;
        int qb;
        int t;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // ---- directed transactions ----
        send(CMD_QUERY, 5, 5);          // query on an empty tree
        send(CMD_ADD, 0, 0);            // node zero is never valid
        send(CMD_ADD, MAX_ID, 0);       // highest id as a root
        pause($urandom_range(0, 3));
        send(CMD_ADD, 1, MAX_ID);
        send(CMD_ADD, 1, MAX_ID);       // duplicate add
        send(CMD_ADD, 7, 7);            // a node as its own parent
        send(CMD_ADD, 8, 500);          // parent not loaded
        pause($urandom_range(0, 3));
        send(CMD_ADD, 2, 1);
        send(CMD_ADD, 3, 1);
        send(CMD_ADD, 4, 2);
        send(CMD_ADD, 512, 0);          // second tree
        send(CMD_ADD, 341, 512);        // alternating bit pattern in node_a
        send(CMD_ADD, 682, 341);
        pause($urandom_range(0, 3));
        send(CMD_QUERY, 4, 3);          // siblings' subtrees meet at 1
        send(CMD_QUERY, 4, 4);          // same node twice
        send(CMD_QUERY, 4, MAX_ID);     // other node is the root
        send(CMD_QUERY, MAX_ID, 4);     // deeper node second
        send(CMD_QUERY, 682, 4);        // different trees
        send(CMD_QUERY, 0, 4);          // node zero as an operand
        send(CMD_QUERY, 4, 0);
        send(CMD_QUERY, 5, 4);          // operand never loaded
        send(CMD_QUERY, 2, 4);          // one node is an ancestor of the other
        send(CMD_QUERY, MAX_ID, MAX_ID);
        pause($urandom_range(0, 3));

        // ---- random transactions in bursts ----
        // Mostly well-formed adds that extend one long chain, so that queries between
        // the chain bottom and shallow nodes use the high lifting levels; the rest are
        // queries on loaded nodes and a little noise.
        rand_cnt = 0;
        while (rand_cnt < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 16);
            for (int j = 0; j < burst && rand_cnt < RANDOM_ITEMS; j++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 58)
                begin
                    fresh = pick_fresh();
                    roll  = $urandom_range(0, 99);
                    if (roll < 85)
                        par = tip;
                    else if (roll < 95)
                        par = pick_loaded();
                    else
                        par = 0;                // new root, more separate trees
                    send(CMD_ADD, fresh, par);
                end
                else if (roll < 90)
                begin
                    qa = $urandom_range(0, 1) ? tip : pick_loaded();
                    qb = ($urandom_range(0, 9) == 0) ? qa : pick_loaded();
                    if ($urandom_range(0, 1))
                    begin
                        t  = qa;
                        qa = qb;
                        qb = t;
                    end
                    send(CMD_QUERY, qa, qb);
                end
                else
                begin
                    case ($urandom_range(0, 3))
                        0: send(1'($urandom_range(0, 1)), $urandom_range(0, MAX_ID),
                                $urandom_range(0, MAX_ID));
                        1: send(CMD_ADD, pick_loaded(), pick_loaded());
                        2:
                        begin
                            fresh = pick_fresh();
                            send(CMD_ADD, fresh, fresh);
                        end
                        default: send(CMD_QUERY, pick_fresh(), pick_loaded());
                    endcase
                end
                rand_cnt++;
            end
            // one burst in five runs straight into the next
            pause(($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 10));
        end
        req_valid <= 1'b0;

        // wait out every outstanding response, then watch for strays
        while (waiting != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/lcab_pkg.sv
hw/rtl/lcab_seq.sv
hw/rtl/lcab_dp.sv
hw/rtl/lca_binary_lifting.sv
bench/lcab_answer_check.sv
bench/lca_binary_lifting_tb.sv
